>>> sv/sm_pkg.sv
// Shared widths, defaults and exp tables for the softmax normalizer.
package sm_pkg;

	localparam int SCORE_W   = 16;
	localparam int PROB_W    = 16;
	localparam int EXP_W     = 28;
	localparam int TOTAL_W   = 34;
	localparam int FRAC_W    = 18;
	localparam int INTP_W    = 31;
	localparam int MAX_LEN_D = 64;

	// Fractional exp, round(e^(k/16) * 2^16), Q2.16
	function automatic logic [FRAC_W-1:0] frac_lut(input logic [4:0] k);
		logic [FRAC_W-1:0] v;
		case (k)
			5'd0:    v = 18'd65536;
			5'd1:    v = 18'd69763;
			5'd2:    v = 18'd74262;
			5'd3:    v = 18'd79052;
			5'd4:    v = 18'd84150;
			5'd5:    v = 18'd89577;
			5'd6:    v = 18'd95354;
			5'd7:    v = 18'd101504;
			5'd8:    v = 18'd108051;
			5'd9:    v = 18'd115019;
			5'd10:   v = 18'd122437;
			5'd11:   v = 18'd130334;
			5'd12:   v = 18'd138740;
			5'd13:   v = 18'd147688;
			5'd14:   v = 18'd157213;
			5'd15:   v = 18'd167352;
			5'd16:   v = 18'd178145;
			default: v = 18'd0;
		endcase
		return v;
	endfunction

	// Integer exp, round(e^n * 2^20) for n = -8..7, indexed by n + 8
	function automatic logic [INTP_W-1:0] intp_lut(input logic [3:0] k);
		logic [INTP_W-1:0] v;
		case (k)
			4'd0:    v = 31'd352;
			4'd1:    v = 31'd956;
			4'd2:    v = 31'd2599;
			4'd3:    v = 31'd7065;
			4'd4:    v = 31'd19205;
			4'd5:    v = 31'd52206;
			4'd6:    v = 31'd141909;
			4'd7:    v = 31'd385750;
			4'd8:    v = 31'd1048576;
			4'd9:    v = 31'd2850325;
			4'd10:   v = 31'd7747987;
			4'd11:   v = 31'd21061212;
			4'd12:   v = 31'd57250310;
			4'd13:   v = 31'd155622477;
			4'd14:   v = 31'd423025751;
			default: v = 31'd1149903211;
		endcase
		return v;
	endfunction

endpackage

>>> sv/softmax_normalizer_top.sv
// Softmax normalizer top: exp store, running total and emission sequencer.
// Usage:
//  Scores enter on the input channel (score, last_in) one transaction per
//  cycle while the block is loading. Each score passes a two-stage exp unit
//  and its result is written to the exp RAM and added to the running total.
//  A score with last_in set, or the MAX_LEN-th score, closes the vector; the
//  input then stalls until the last probability enters the output register.
//  Emission: once the exp pipeline has drained, each stored exp is
//  read from the RAM (a read, then a read wait) and divided by the total
//  in a bit-serial divider (17 steps), then loaded into the output
//  register; the next exp is read only once that result is loaded. The
//  probabilities leave in arrival order, last_out set on the final one.
//  Loading throughput is one score per cycle while in_stall is low.
//  The result sits in an output register; while out_stall is high it holds,
//  and the next division proceeds underneath it.
//  Reset clears the total, the counters and the sequencer; the RAM needs no
//  clearing since only entries of the current vector are read.
module softmax_normalizer_top #(
	parameter int MAX_LEN = sm_pkg::MAX_LEN_D
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [sm_pkg::SCORE_W-1:0] score,
	input  logic                       last_in,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [sm_pkg::PROB_W-1:0]  probability,
	output logic                       last_out
);
	import sm_pkg::*;

	localparam int AW = $clog2(MAX_LEN);

	typedef enum logic [2:0] {
		ST_LOAD, ST_DRAIN, ST_READ, ST_RWAIT, ST_DIV, ST_OUT
	} state_t;

	state_t             state_q;
	logic [AW-1:0]      cnt_q;
	logic [AW-1:0]      last_idx_q;
	logic [AW-1:0]      wptr_q;
	logic [AW-1:0]      rd_idx_q;
	logic [TOTAL_W-1:0] total_q;
	logic               in_acc;
	logic               exp_valid;
	logic [EXP_W-1:0]   exp_val;
	logic [EXP_W-1:0]   rdata;
	logic               div_start;
	logic               div_busy;
	logic [PROB_W-1:0]  div_quot;
	logic               out_free;
	logic               out_load;
	logic               out_valid_q;
	logic [PROB_W-1:0]  prob_q;
	logic               last_q;
	logic               exp_pipe_q;

	assign in_stall  = state_q != ST_LOAD;
	assign in_acc    = in_valid && !in_stall;
	assign div_start = state_q == ST_RWAIT;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_load  = state_q == ST_OUT && out_free;

	sm_exp u_exp (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (in_acc),
		.score     (score),
		.valid_out (exp_valid),
		.exp_val   (exp_val)
	);

	sm_ram #(.WIDTH(EXP_W), .DEPTH(MAX_LEN)) u_ram (
		.clk   (clk),
		.we    (exp_valid),
		.waddr (wptr_q),
		.wdata (exp_val),
		.re    (state_q == ST_READ),
		.raddr (rd_idx_q),
		.rdata (rdata)
	);

	sm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.value  (rdata),
		.total  (total_q),
		.busy   (div_busy),
		.quot   (div_quot)
	);

	// Exp pipeline still holds an item past its first stage
	function automatic logic u_exp_busy();
		return exp_pipe_q;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_pipe_q <= 1'b0;
		end else begin
			exp_pipe_q <= in_acc;
		end
	end

	// Sequence load, drain and emission
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			last_idx_q  <= '0;
			wptr_q      <= '0;
			rd_idx_q    <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && !out_load) begin
				out_valid_q <= 1'b0;
			end
			if (exp_valid) begin
				wptr_q  <= wptr_q + 1'b1;
				total_q <= total_q + TOTAL_W'(exp_val);
			end
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						cnt_q <= cnt_q + 1'b1;
						if (last_in || cnt_q == AW'(MAX_LEN - 1)) begin
							last_idx_q <= cnt_q;
							state_q    <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (!exp_valid && !u_exp_busy()) begin
						rd_idx_q <= '0;
						state_q  <= ST_READ;
					end
				end
				ST_READ:  state_q <= ST_RWAIT;
				ST_RWAIT: state_q <= ST_DIV;
				ST_DIV: begin
					if (!div_busy) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (rd_idx_q == last_idx_q) begin
							cnt_q   <= '0;
							wptr_q  <= '0;
							total_q <= '0;
							state_q <= ST_LOAD;
						end else begin
							rd_idx_q <= rd_idx_q + 1'b1;
							state_q  <= ST_READ;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// Output payload register
	always_ff @(posedge clk) begin
		if (out_load) begin
			prob_q <= div_quot;
			last_q <= rd_idx_q == last_idx_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign probability = prob_q;
	assign last_out    = last_q;

	// Checks
	a_no_write_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		exp_valid |-> (state_q == ST_LOAD || state_q == ST_DRAIN))
		else $error("exp write during emission");
	a_total_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && rd_idx_q == last_idx_q) |=> total_q == '0)
		else $error("total not cleared after vector");
	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider restarted while busy");

endmodule

>>> sv/sm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module sm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sv/sm_exp.sv
// Two-stage fixed-point exp: table interpolation, then integer-power scaling.
module sm_exp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       valid_in,
	input  logic [sm_pkg::SCORE_W-1:0] score,
	output logic                       valid_out,
	output logic [sm_pkg::EXP_W-1:0]   exp_val
);
	import sm_pkg::*;

	logic [3:0]        seg;
	logic [7:0]        rem;
	logic [FRAC_W-1:0] frac_lo;
	logic [FRAC_W-1:0] frac_hi;
	logic [13:0]       diff;
	logic [21:0]       slope;
	logic [FRAC_W-1:0] mant;
	logic              valid_s1;
	logic [FRAC_W-1:0] mant_s1;
	logic [3:0]        idx_s1;
	logic [48:0]       prod;
	logic [28:0]       rnd;
	logic              valid_s2;
	logic [EXP_W-1:0]  exp_s2;

	// Interpolate within the fractional table
	assign seg     = score[11:8];
	assign rem     = score[7:0];
	assign frac_lo = frac_lut({1'b0, seg});
	assign frac_hi = frac_lut({1'b0, seg} + 5'd1);
	assign diff    = 14'(frac_hi - frac_lo);
	assign slope   = diff * rem;
	assign mant    = frac_lo + FRAC_W'((23'(slope) + 23'd128) >> 8);

	// Scale by e^n, round and saturate
	assign prod = 49'(mant_s1) * 49'(intp_lut(idx_s1));
	assign rnd  = 29'((prod + 49'(1 << 19)) >> 20);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		mant_s1 <= mant;
		idx_s1  <= {~score[15], score[14:12]};
		exp_s2  <= rnd[28] ? {EXP_W{1'b1}} : rnd[EXP_W-1:0];
	end

	assign valid_out = valid_s2;
	assign exp_val   = exp_s2;

endmodule

>>> sv/sm_div.sv
// Restoring divider: (value << 16) / total, one quotient bit per cycle.
module sm_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [sm_pkg::EXP_W-1:0]   value,
	input  logic [sm_pkg::TOTAL_W-1:0] total,
	output logic                       busy,
	output logic [sm_pkg::PROB_W-1:0]  quot
);
	import sm_pkg::*;

	localparam int STEPS = PROB_W + 1;

	logic [TOTAL_W:0]             rem_q;
	logic [TOTAL_W-1:0]           div_q;
	logic [PROB_W:0]              quot_q;
	logic [$clog2(STEPS+1)-1:0]   cnt_q;
	logic                         zero_q;
	logic                         ge;
	logic [TOTAL_W:0]             diffr;

	assign ge    = rem_q >= {1'b0, div_q};
	assign diffr = ge ? rem_q - {1'b0, div_q} : rem_q;

	// Count down the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= ($clog2(STEPS+1))'(STEPS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Compare, subtract, shift
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= (TOTAL_W+1)'(value);
			div_q  <= total;
			quot_q <= '0;
			zero_q <= total == '0;
		end else if (cnt_q != '0) begin
			rem_q  <= {diffr[TOTAL_W-1:0], 1'b0};
			quot_q <= {quot_q[PROB_W-1:0], ge};
		end
	end

	assign busy = cnt_q != '0;
	assign quot = zero_q ? '0 : (quot_q[PROB_W] ? {PROB_W{1'b1}} : quot_q[PROB_W-1:0]);

endmodule

>>> tb/tb_top.sv
// Testbench for the softmax normalizer: random vectors, scoreboard, idle phases.
`timescale 1ns / 1ps

class softmax_scoreboard;
	logic [27:0] exp_held[$];
	logic [33:0] exp_sum;
	logic [15:0] prob_q[$];
	logic        last_q[$];
	int          errors;
	int          max_len;

	function new(int len);
		max_len = len;
		exp_sum = '0;
		errors = 0;
	endfunction

	// Fixed-point exp of a Q4.12 score, Q12.16 result
	function logic [27:0] score_exp(logic [15:0] s);
		logic [17:0] frac_tab[17];
		logic [30:0] int_tab[16];
		logic [3:0]  idx;
		logic [3:0]  seg;
		logic [7:0]  r;
		logic [63:0] m;
		logic [63:0] p;
		frac_tab = '{65536, 69763, 74262, 79052, 84150, 89577, 95354, 101504,
			108051, 115019, 122437, 130334, 138740, 147688, 157213, 167352, 178145};
		int_tab = '{352, 956, 2599, 7065, 19205, 52206, 141909, 385750,
			1048576, 2850325, 7747987, 21061212, 57250310, 155622477,
			423025751, 1149903211};
		idx = s[15:12] ^ 4'h8;
		seg = s[11:8];
		r = s[7:0];
		m = frac_tab[seg] + ((64'(frac_tab[seg + 1] - frac_tab[seg]) * r + 128) >> 8);
		p = (m * int_tab[idx] + (64'd1 << 19)) >> 20;
		if (p > 64'h0FFFFFFF)
			p = 64'h0FFFFFFF;
		return p[27:0];
	endfunction

	// Note an accepted score; on vector end queue the probabilities
	function void note_score(logic [15:0] s, logic lst);
		logic [27:0] e;
		logic [63:0] q;
		e = score_exp(s);
		exp_held.push_back(e);
		exp_sum = exp_sum + e;
		if (lst || exp_held.size() >= max_len) begin
			foreach (exp_held[k]) begin
				q = 0;
				if (exp_sum != 0) begin
					q = (64'(exp_held[k]) << 16) / exp_sum;
					if (q > 65535)
						q = 65535;
				end
				prob_q.push_back(q[15:0]);
				last_q.push_back(k == exp_held.size() - 1);
			end
			exp_held.delete();
			exp_sum = '0;
		end
	endfunction

	task report(string what);
		$display("tb: mismatch %s at %0t", what, $time);
		errors++;
	endtask

	// Check one delivered probability against the oldest expectation
	task check_prob(logic [15:0] p, logic lst);
		logic [15:0] ep;
		logic        el;
		if (prob_q.size() == 0) begin
			report($sformatf("unexpected probability %0d", p));
			return;
		end
		ep = prob_q.pop_front();
		el = last_q.pop_front();
		if (p !== ep)
			report($sformatf("probability got %0d want %0d", p, ep));
		if (lst !== el)
			report($sformatf("last_out got %0b want %0b", lst, el));
	endtask

	function int pending();
		return prob_q.size();
	endfunction
endclass

module tb_top;
	import sm_pkg::*;

	localparam int LEN = MAX_LEN_D;
	localparam longint CYCLE_LIMIT = 400000;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [SCORE_W-1:0]  score;
	logic                last_in;
	logic                out_valid;
	logic                out_stall;
	logic [PROB_W-1:0]   probability;
	logic                last_out;

	int     send_idle_pct;
	int     recv_idle_pct;
	longint cycles;
	int     sent;
	softmax_scoreboard sb;

	softmax_normalizer_top #(.MAX_LEN(LEN)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .score(score), .last_in(last_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.probability(probability), .last_out(last_out)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Sample results at the rising edge; end on timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && out_valid && !out_stall)
			sb.check_prob(probability, last_out);
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Stall the result channel at random
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < recv_idle_pct);

	// Offer one score and hold it until accepted; the caller drops valid
	task send_score(logic [15:0] s, logic lst);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		score <= s;
		last_in <= lst;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_score(s, lst);
		sent++;
		@(negedge clk);
	endtask

	// Send a vector of given length with random scores
	task send_vector(int n, int narrow);
		logic [15:0] s;
		for (int i = 0; i < n; i++) begin
			s = narrow ? 16'($signed($urandom_range(8192)) - 4096) : 16'($urandom);
			send_score(s, i == n - 1);
		end
	endtask

	task drain();
		in_valid <= 0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task random_phase(int items);
		int n;
		int target;
		target = sent + items;
		while (sent < target) begin
			n = ($urandom_range(9) == 0) ? $urandom_range(LEN + 8, 2)
				: $urandom_range(6, 1);
			send_vector(n, $urandom_range(1));
		end
	endtask

	initial begin
		sb = new(LEN);
		cycles = 0;
		sent = 0;
		arst_n = 0;
		in_valid = 0;
		score = '0;
		last_in = 0;
		out_stall = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (10) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: lone element, field extremes, full vector overflow
		send_score(16'h0000, 1);
		send_score(16'h7FFF, 1);
		send_score(16'h8000, 1);
		send_score(16'h8000, 0);
		send_score(16'h7FFF, 0);
		send_score(16'h0FFF, 0);
		send_score(16'hF000, 0);
		send_score(16'h00FF, 1);
		send_score(16'h5555, 0);
		send_score(16'hAAAA, 1);
		drain();
		send_vector(LEN + 2, 1);
		drain();

		send_idle_pct = 29;
		recv_idle_pct = 86;
		random_phase(70);
		drain();
		send_idle_pct = 86;
		recv_idle_pct = 29;
		random_phase(60);
		drain();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(60);
		drain();

		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
